// File: sv/epoc_pkg.sv
package epoc_pkg;

    localparam int PAGES        = 32768;
    localparam int MAX_CONTEXTS = 20;
    localparam int PAGE_BITS    = 12;

    localparam int ADDR_W   = 56;
    localparam int VADDR_W  = 64;
    localparam int VPN_W    = VADDR_W - PAGE_BITS;
    localparam int PNUM_W   = ADDR_W - PAGE_BITS;
    localparam int IDX_W    = $clog2(PAGES);
    localparam int CTX_W    = 5;
    localparam int TID_W    = 8;
    localparam int CODE_W   = 4;
    localparam int NID_W    = 5;
    localparam int CNT_W    = $clog2(MAX_CONTEXTS + 2);
    localparam int ENTRY_W  = CTX_W + VPN_W;

    localparam int IN_W     = 2 + CTX_W + 1 + VADDR_W + ADDR_W + TID_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = 1 + CODE_W + NID_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam logic [CTX_W-1:0] CTX_NORMAL  = CTX_W'(1);
    localparam logic [CNT_W-1:0] FIRST_ID    = CNT_W'(2);

    typedef enum logic [1:0] {
        CFG_MEM_BASE = 2'd0,
        CFG_MEM_TOP  = 2'd1,
        CFG_FW_START = 2'd2,
        CFG_FW_END   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_CREATE = 2'd1,
        OP_ADD    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [CODE_W-1:0] {
        FC_NONE         = 4'd0,
        FC_FIRMWARE     = 4'd1,
        FC_FETCH_UNOWN  = 4'd2,
        FC_VA_MISMATCH  = 4'd3,
        FC_ENCL_PAGE    = 4'd4,
        FC_NOT_NORMAL   = 4'd5,
        FC_NO_SLOT      = 4'd6,
        FC_BAD_ID       = 4'd7,
        FC_OCCUPIED     = 4'd8,
        FC_OUT_OF_RANGE = 4'd9
    } fault_t;

    // Decoded item held while its table entry is read.
    typedef struct packed {
        opcode_t           op;
        logic [CTX_W-1:0]  ctx;
        logic              fetch;
        logic [VPN_W-1:0]  vpn;
        logic [TID_W-1:0]  tid;
        logic              fw_hit;
        logic              out_mem;
        logic              in_table;
        logic [IDX_W-1:0]  idx;
    } stage_t;

endpackage

// File: sv/enclave_page_ownership_checker.sv
// Enclave page ownership checker. Items arrive on s_* and each gives exactly one result on
// m_*. Every page of protected memory has one entry in an on-chip table (owner id and
// virtual page number), read as the item is taken and written back when
// an add page item completes; a write to the entry that the following item reads is
// forwarded, so the block sustains one item per cycle unless m_tready stalls the output.
// After reset the owner table is cleared one entry a cycle, PAGES (32768) entries in all;
// s_tready stays low until that pass ends, while configuration writes are taken at any
// time. Write the four address registers only while no item is in flight.
module enclave_page_ownership_checker
    import epoc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [ADDR_W-1:0]      cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode[1:0], ctx_id[6:2], is_fetch[7], vaddr[71:8], paddr[127:72], target_id[135:128]
    input  logic [8*IN_BYTES-1:0]  s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accept[0], fault_code[4:1], new_id[9:5], zero fill above
    output logic [8*OUT_BYTES-1:0] m_tdata
);

    // Configuration registers
    logic [ADDR_W-1:0] mem_base_reg, mem_top_reg, fw_start_reg, fw_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_base_reg <= ADDR_W'(64'h8000_0000);
            mem_top_reg  <= ADDR_W'(64'h8800_0000);
            fw_start_reg <= '0;
            fw_end_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MEM_BASE: mem_base_reg <= cfg_wdata;
                CFG_MEM_TOP:  mem_top_reg  <= cfg_wdata;
                CFG_FW_START: fw_start_reg <= cfg_wdata;
                CFG_FW_END:   fw_end_reg   <= cfg_wdata;
            endcase
        end
    end

    // Input unpacking
    logic [1:0]         in_op;
    logic [CTX_W-1:0]   in_ctx;
    logic               in_fetch;
    logic [VADDR_W-1:0] in_va;
    logic [ADDR_W-1:0]  in_pa;
    logic [TID_W-1:0]   in_tid;

    assign in_op    = s_tdata[1:0];
    assign in_ctx   = s_tdata[2 +: CTX_W];
    assign in_fetch = s_tdata[2 + CTX_W];
    assign in_va    = s_tdata[3 + CTX_W +: VADDR_W];
    assign in_pa    = s_tdata[3 + CTX_W + VADDR_W +: ADDR_W];
    assign in_tid   = s_tdata[3 + CTX_W + VADDR_W + ADDR_W +: TID_W];

    // Control state
    logic             clr_done_reg, clr_done_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic [CNT_W-1:0] next_id_reg, next_id_next;
    logic             fwd_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic s_fire, s1_adv;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = clr_done_reg && (!s1_valid_reg || s1_adv);
    assign s_fire   = s_tvalid && s_tready;

    // Stage 0: range decode of the physical address, table index
    logic [ADDR_W-1:0] pa_off;
    logic [PNUM_W-1:0] pnum;
    stage_t            s0;

    always_comb begin
        pa_off      = in_pa - mem_base_reg;
        pnum        = pa_off[ADDR_W-1:PAGE_BITS];
        s0.op       = opcode_t'(in_op);
        s0.ctx      = in_ctx;
        s0.fetch    = in_fetch;
        s0.vpn      = in_va[VADDR_W-1:PAGE_BITS];
        s0.tid      = in_tid;
        s0.fw_hit   = (in_pa >= fw_start_reg) && (in_pa < fw_end_reg);
        s0.out_mem  = (in_pa < mem_base_reg) || (in_pa >= mem_top_reg);
        s0.in_table = pnum < PNUM_W'(PAGES);
        s0.idx      = pnum[IDX_W-1:0];
    end

    // Table memory: {owner, vpn} per page
    logic [ENTRY_W-1:0] table_mem [PAGES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               add_wr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= table_mem[s0.idx];
        end
    end

    // Stage 1: resolve against the entry, build the result
    logic [ENTRY_W-1:0] entry;
    logic [CTX_W-1:0]   owner;
    logic [VPN_W-1:0]   ent_vpn;
    logic               acc;
    fault_t             code;
    logic [NID_W-1:0]   nid;
    logic               id_inc;

    always_comb begin
        entry   = fwd_reg ? fwd_data_reg : rd_data_reg;
        owner   = entry[ENTRY_W-1:VPN_W];
        ent_vpn = entry[VPN_W-1:0];
        acc     = 1'b0;
        code    = FC_NONE;
        nid     = '0;
        add_wr  = 1'b0;
        id_inc  = 1'b0;
        unique case (s1_reg.op)
            OP_CHECK: begin
                priority if (s1_reg.fw_hit) begin
                    code = FC_FIRMWARE;
                end else if (s1_reg.out_mem) begin
                    code = FC_NONE;
                end else if (!s1_reg.in_table) begin
                    code = FC_OUT_OF_RANGE;
                end else if (s1_reg.ctx > CTX_NORMAL) begin
                    if (owner != s1_reg.ctx && s1_reg.fetch) begin
                        code = FC_FETCH_UNOWN;
                    end else if (owner != '0 && ent_vpn != s1_reg.vpn) begin
                        code = FC_VA_MISMATCH;
                    end
                end else if (owner > CTX_NORMAL) begin
                    code = FC_ENCL_PAGE;
                end
                acc = (code == FC_NONE);
            end
            OP_CREATE: begin
                priority if (s1_reg.ctx != CTX_NORMAL) begin
                    code = FC_NOT_NORMAL;
                end else if (next_id_reg > CNT_W'(MAX_CONTEXTS)) begin
                    code = FC_NO_SLOT;
                end else begin
                    nid    = NID_W'(next_id_reg);
                    id_inc = 1'b1;
                    acc    = 1'b1;
                end
            end
            OP_ADD: begin
                priority if (s1_reg.ctx != CTX_NORMAL) begin
                    code = FC_NOT_NORMAL;
                end else if (s1_reg.tid < TID_W'(2)
                             || s1_reg.tid >= TID_W'(next_id_reg)) begin
                    code = FC_BAD_ID;
                end else if (s1_reg.out_mem || !s1_reg.in_table) begin
                    code = FC_OUT_OF_RANGE;
                end else if (owner != '0) begin
                    code = FC_OCCUPIED;
                end else begin
                    add_wr = 1'b1;
                    acc    = 1'b1;
                end
            end
            OP_NONE: begin
                code = FC_NONE;
            end
        endcase
    end

    // Write port: clearing pass after reset, else completed add items
    always_comb begin
        if (!clr_done_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_adv && add_wr;
            mem_waddr = s1_reg.idx;
            mem_wdata = {CTX_W'(s1_reg.tid), s1_reg.vpn};
        end
    end

    // Forward a write-back to the item whose read of the same entry happens alongside it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_reg <= mem_we && clr_done_reg && (mem_waddr == s0.idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_data_reg <= mem_wdata;
        end
    end

    // Next-state logic for control
    always_comb begin
        clr_done_next  = clr_done_reg;
        clr_idx_next   = clr_idx_reg;
        if (!clr_done_reg) begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(PAGES - 1)) begin
                clr_done_next = 1'b1;
            end
        end
        // advance stage 1 when the output register frees up, refill from the input
        s1_valid_next = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        next_id_next   = (s1_adv && id_inc) ? next_id_reg + CNT_W'(1) : next_id_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_done_reg  <= 1'b0;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            next_id_reg   <= FIRST_ID;
        end else begin
            clr_done_reg  <= clr_done_next;
            clr_idx_reg   <= clr_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            next_id_reg   <= next_id_next;
        end
    end

    // Payload registers hold while stalled
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg <= s0;
        end
        if (s1_adv) begin
            out_data_reg <= {nid, code, acc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (8*OUT_BYTES)'(out_data_reg);

    // Assertions
    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_done_reg |-> !s_tready)
        else $error("item taken during table clearing pass");

    a_accept_has_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] == FC_NONE)
        else $error("accepted result carries a fault code");

    a_new_id_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:5] != '0 |-> m_tdata[0])
        else $error("new id given on a rejected item");

    a_id_counter_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> next_id_reg >= $past(next_id_reg))
        else $error("enclave id counter went backward");

    a_id_counter_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg <= CNT_W'(MAX_CONTEXTS + 1))
        else $error("enclave id counter beyond its limit");

endmodule
